>>> hw/rtl/rrvm_pkg.sv
`default_nettype none

package rrvm_pkg;

   // Address and size widths
   localparam int unsigned RRVM_ADDR_WIDTH  = 64;
   localparam int unsigned RRVM_TYPE_WIDTH  = 32;
   localparam int unsigned RRVM_PAGES_WIDTH = 52;
   localparam int unsigned RRVM_ATTR_WIDTH  = 64;

   // Alignment granules as bit counts: 4 KiB page, 64 KiB, 2 MiB
   localparam int unsigned RRVM_PAGE_BITS   = 12;
   localparam int unsigned RRVM_SZ_64K_BITS = 16;
   localparam int unsigned RRVM_SZ_2M_BITS  = 21;

   // Attribute bits
   localparam int unsigned RRVM_RUNTIME_BIT  = 63;
   localparam int unsigned RRVM_CACHE_BITS   = 4;

   // Configuration
   localparam int unsigned RRVM_CSR_ADDR_WIDTH = 3;
   localparam int unsigned RRVM_CSR_DATA_WIDTH = 64;
   localparam logic [RRVM_CSR_ADDR_WIDTH-1:0] RRVM_ADDR_VIRT_BASE_START = 3'd0;
   localparam logic [RRVM_ADDR_WIDTH-1:0] RRVM_VIRT_BASE_RESET = 64'h0000_0000_2000_0000;

   // Depth of the queue between front and back
   localparam int unsigned RRVM_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic                        first_of_map;
      logic [RRVM_TYPE_WIDTH-1:0]  mem_type;
      logic [RRVM_ADDR_WIDTH-1:0]  physical_start;
      logic [RRVM_PAGES_WIDTH-1:0] page_count;
      logic [RRVM_ATTR_WIDTH-1:0]  attribute;
   } rrvm_req_type;

   typedef struct packed {
      logic [RRVM_TYPE_WIDTH-1:0]  out_type;
      logic [RRVM_ADDR_WIDTH-1:0]  out_physical_start;
      logic [RRVM_ADDR_WIDTH-1:0]  virtual_start;
      logic [RRVM_PAGES_WIDTH-1:0] out_page_count;
      logic [RRVM_ATTR_WIDTH-1:0]  out_attribute;
   } rrvm_rsp_type;

   // Classified descriptor handed from front to back
   typedef struct packed {
      rrvm_req_type               req;
      logic                       runtime;
      logic                       linked;
      logic                       big;    // base rounds to 2 MiB
      logic [RRVM_ADDR_WIDTH-1:0] size;   // bytes, grown by 64 KiB offset unless linked
   } rrvm_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/rrvm_front.sv
`default_nettype none

module rrvm_front
   import rrvm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   input  wire rrvm_req_type req_data,
   input  wire logic         q_full,
   output logic              q_push,
   output rrvm_cmd_type      q_data
);

   localparam int unsigned CacheW = RRVM_CACHE_BITS + 1;

   logic [RRVM_ADDR_WIDTH-1:0] prev_end_ff, prev_end_in;
   logic [CacheW-1:0]          prev_bits_ff, prev_bits_in;
   logic                       prev_present_ff, prev_present_in;

   logic                       accept;
   logic                       runtime;
   logic                       linked;
   logic [CacheW-1:0]          bits;
   logic [RRVM_ADDR_WIDTH-1:0] size_raw;
   logic [RRVM_ADDR_WIDTH-1:0] size_grown;
   logic [RRVM_ADDR_WIDTH-1:0] offset_ext;

   assign accept  = req_push && !q_full;
   assign runtime = req_data.attribute[RRVM_RUNTIME_BIT];
   assign bits    = {runtime, req_data.attribute[RRVM_CACHE_BITS-1:0]};

   // Region size in bytes and its 64 KiB alignment growth
   assign size_raw   = {req_data.page_count, {RRVM_PAGE_BITS{1'b0}}};
   assign offset_ext = {{(RRVM_ADDR_WIDTH-RRVM_SZ_64K_BITS){1'b0}},
                        req_data.physical_start[RRVM_SZ_64K_BITS-1:0]};
   assign size_grown = size_raw + offset_ext;

   // Adjacent with matching attributes continues the previous mapping
   assign linked = !req_data.first_of_map && prev_present_ff &&
                   (prev_end_ff == req_data.physical_start) && (prev_bits_ff == bits);

   // Only runtime descriptors and map starts matter to the back end
   always_comb begin
      q_push         = accept && (runtime || req_data.first_of_map);
      q_data.req     = req_data;
      q_data.runtime = runtime;
      q_data.linked  = linked;
      // 2 MiB aligned start means no growth, so the raw size decides
      q_data.big     = (req_data.physical_start[RRVM_SZ_2M_BITS-1:0] == '0) &&
                       (size_raw[RRVM_ADDR_WIDTH-1:RRVM_SZ_2M_BITS] != '0);
      q_data.size    = linked ? size_raw : size_grown;
   end

   // Previous descriptor tracking
   always_comb begin
      prev_end_in     = prev_end_ff;
      prev_bits_in    = prev_bits_ff;
      prev_present_in = prev_present_ff;
      if (accept) begin
         prev_end_in     = req_data.physical_start + size_raw;
         prev_bits_in    = bits;
         prev_present_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_end_ff     <= '0;
         prev_bits_ff    <= '0;
         prev_present_ff <= 1'b0;
      end else begin
         prev_end_ff     <= prev_end_in;
         prev_bits_ff    <= prev_bits_in;
         prev_present_ff <= prev_present_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Plain non-runtime words never reach the back end
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_data.attribute[RRVM_RUNTIME_BIT] || req_data.first_of_map))
      else $error("front pushed a word that needs no back-end work");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/rrvm_queue.sv
`default_nettype none

module rrvm_queue
   import rrvm_pkg::*;
#(
   parameter int unsigned Depth = RRVM_QUEUE_DEPTH
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rrvm_cmd_type push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              valid,
   output rrvm_cmd_type      pop_data
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   rrvm_cmd_type    entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign valid    = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue lost a pushed word");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/rrvm_back.sv
`default_nettype none

module rrvm_back
   import rrvm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [RRVM_ADDR_WIDTH-1:0] virt_base_start,
   input  wire logic                       q_valid,
   input  wire rrvm_cmd_type               q_data,
   output logic                            q_pop,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output rrvm_rsp_type                    rsp_data
);

   localparam int unsigned AW    = RRVM_ADDR_WIDTH;
   localparam int unsigned Lo64k = RRVM_SZ_64K_BITS;
   localparam int unsigned Lo2m  = RRVM_SZ_2M_BITS;
   localparam int unsigned Hi64k = AW - Lo64k;
   localparam int unsigned Hi2m  = AW - Lo2m;

   logic [AW-1:0] base_ff, base_in;
   logic          out_valid_ff, out_valid_in;
   rrvm_rsp_type  out_ff, out_in;

   logic             take;
   logic [AW-1:0]    base;
   logic             inc64k;
   logic             inc2m;
   logic [Hi64k-1:0] up64k;
   logic [Hi2m-1:0]  up2m;
   logic [Hi64k-1:0] sum64k_hi;
   logic [Hi2m-1:0]  sum2m_hi;
   logic [AW-1:0]    sum_linked;
   logic [AW-1:0]    vstart;
   logic [AW-1:0]    base_next;

   // Take a command whenever the output slot is free or being drained
   assign take      = q_valid && (!out_valid_ff || rsp_pop);
   assign q_pop     = take;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Running base, reloaded at the start of a map
   assign base = q_data.req.first_of_map ? virt_base_start : base_ff;

   // Round-up carries and rounded bases
   assign inc64k = (base[Lo64k-1:0] != '0);
   assign inc2m  = (base[Lo2m-1:0] != '0);
   assign up64k  = base[AW-1:Lo64k] + Hi64k'(inc64k);
   assign up2m   = base[AW-1:Lo2m] + Hi2m'(inc2m);

   // Rounded base plus size, folded into one add each
   assign sum64k_hi  = base[AW-1:Lo64k] + q_data.size[AW-1:Lo64k] + Hi64k'(inc64k);
   assign sum2m_hi   = base[AW-1:Lo2m] + q_data.size[AW-1:Lo2m] + Hi2m'(inc2m);
   assign sum_linked = base + q_data.size;

   always_comb begin
      if (q_data.linked) begin
         vstart    = base;
         base_next = sum_linked;
      end else if (q_data.big) begin
         vstart    = {up2m, {Lo2m{1'b0}}};
         base_next = {sum2m_hi, q_data.size[Lo2m-1:0]};
      end else begin
         vstart    = {up64k, q_data.req.physical_start[Lo64k-1:0]};
         base_next = {sum64k_hi, q_data.size[Lo64k-1:0]};
      end
   end

   // Base and output word update
   always_comb begin
      base_in      = base_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (take) begin
         if (q_data.runtime) begin
            base_in                   = base_next;
            out_valid_in              = 1'b1;
            out_in.out_type           = q_data.req.mem_type;
            out_in.out_physical_start = q_data.req.physical_start;
            out_in.virtual_start      = vstart;
            out_in.out_page_count     = q_data.req.page_count;
            out_in.out_attribute      = q_data.req.attribute;
         end else begin
            base_in = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= RRVM_VIRT_BASE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (take && q_data.runtime) |=> out_valid_ff)
      else $error("runtime descriptor produced no word");

   assert property (@(posedge clock) disable iff (reset)
      (take && !q_data.runtime) |=> !out_valid_ff)
      else $error("map start without runtime bit produced a word");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/runtime_region_virtual_mapper_core.sv
// Runtime region virtual mapper.
// Request side is a queue input: a descriptor word (rrvm_req_type) is taken at
// a clock edge with req_push high and req_full low. Descriptors arrive sorted
// by physical start; each runtime descriptor (attribute bit 63) yields one
// response word with its assigned virtual start, others yield none.
// Response side is a queue output: the oldest word sits on rsp_data while
// rsp_empty is low and leaves at an edge with rsp_pop high.
// One descriptor is taken per cycle while req_full is low. The front end checks adjacency
// against the previous descriptor, the back end updates the running base
// through parallel adds. An accepted runtime descriptor passes the front-to-back
// queue and the output register before its word shows on rsp_data.
// When the receiver stalls, the output slot holds its word and the
// front-to-back queue fills; req_full rises once it is full.
// Reset (synchronous, active high) empties both queues, forgets the previous
// descriptor and loads the base and virt_base_start with 0x2000_0000.
// csr: APB-style, virt_base_start at address 0; writes are meant for idle
// periods and take effect at the next map start.
`default_nettype none

module runtime_region_virtual_mapper_core
   import rrvm_pkg::*;
#(
   parameter int unsigned QueueDepth = RRVM_QUEUE_DEPTH
)(
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request queue
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire rrvm_req_type                   req_data,
   // response queue
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output rrvm_rsp_type                        rsp_data,
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [RRVM_CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [RRVM_CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [RRVM_CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   logic [RRVM_ADDR_WIDTH-1:0] virt_base_start_ff, virt_base_start_in;
   logic                       csr_write;

   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_valid;
   rrvm_cmd_type q_in_data;
   rrvm_cmd_type q_out_data;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      virt_base_start_in = virt_base_start_ff;
      if (csr_write && (csr_paddr == RRVM_ADDR_VIRT_BASE_START)) begin
         virt_base_start_in = csr_pwdata;
      end
      csr_prdata = (csr_paddr == RRVM_ADDR_VIRT_BASE_START) ? virt_base_start_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         virt_base_start_ff <= RRVM_VIRT_BASE_RESET;
      end else begin
         virt_base_start_ff <= virt_base_start_in;
      end
   end

   assign req_full = q_full;

   rrvm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   rrvm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out_data)
   );

   rrvm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .virt_base_start (virt_base_start_ff),
      .q_valid         (q_valid),
      .q_data          (q_out_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data)
   );

endmodule

`default_nettype wire
